[rtl/core/sccb_pkg.sv]
// sccb_pkg: shared types and constants for the sccb bus master
// request payloads, result payloads, command and status codes
// no dependencies
package sccb_pkg;

	// largest read burst, longer requests are clamped
	localparam logic [4:0] MAX_READ_LEN = 5'd16;

	// device write address after reset
	localparam logic [7:0] DEV_ADDR_RESET = 8'h42;

	// request kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// completion status
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_START_FAIL = 2'd1;
	localparam logic [1:0] ST_NO_ACK     = 2'd2;

	// one bus half-period tick with optional command
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [4:0] read_length;
		logic       sda_in;
	} cmd_t;

	// bus levels and status after one tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic       data_valid;
		logic [7:0] read_data;
		logic       data_last;
		logic       rejected;
	} res_t;

endpackage

[rtl/core/sccb_ifs.sv]
// sccb_ifs: valid/ready channel interfaces for the sccb bus master
// tick request channel, result channel and device address write channel
// depends on sccb_pkg
interface sccb_cmd_if import sccb_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sccb_res_if import sccb_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sccb_cfg_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/sccb_engine.sv]
// sccb_engine: bus sequencer, one half-period step per accepted tick
// holds the protocol state and the registered result of the last step
// depends on sccb_pkg
module sccb_engine import sccb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cmd_t       item,
	input  logic [7:0] dev_addr,
	output res_t       res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START1,
		PH_DEVW,
		PH_REG,
		PH_WDATA,
		PH_STOP_MID,
		PH_START2,
		PH_DEVR,
		PH_RBYTE,
		PH_STOP_END,
		PH_STOP_ABORT
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] sub_q, sub_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;
	logic [4:0] left_q, left_d;
	logic [7:0] reg_addr_q, reg_addr_d;
	logic [7:0] wdata_q, wdata_d;
	logic       rd_mode_q, rd_mode_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	res_t       res_q, res_d;

	logic       cmd;
	logic       sda;
	logic [4:0] left_dec;
	logic [7:0] shift_in;

	assign cmd      = (item.kind == KIND_WRITE) || (item.kind == KIND_READ);
	assign sda      = item.sda_in;
	assign left_dec = (left_q != 5'd0) ? left_q - 5'd1 : 5'd0;
	assign shift_in = {shift_q[6:0], sda};

	// next state and result for one tick
	always_comb begin
		phase_d    = phase_q;
		sub_d      = sub_q;
		bits_d     = bits_q;
		shift_d    = shift_q;
		left_d     = left_q;
		reg_addr_d = reg_addr_q;
		wdata_d    = wdata_q;
		rd_mode_d  = rd_mode_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		res_d      = '0;

		if (phase_q == PH_IDLE) begin
			// new command, first start step happens now
			if (cmd) begin
				reg_addr_d = item.reg_addr;
				wdata_d    = item.write_data;
				rd_mode_d  = (item.kind == KIND_READ);
				left_d     = (item.read_length > MAX_READ_LEN) ? MAX_READ_LEN
					: item.read_length;
				scl_d      = 1'b1;
				sda_d      = 1'b1;
				phase_d    = PH_START1;
				sub_d      = 2'd1;
			end
		end else begin
			res_d.rejected = cmd;
			unique case (phase_q)
				// start condition with bus check
				PH_START1, PH_START2: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						if (!sda) begin
							scl_d          = 1'b1;
							sda_d          = 1'b1;
							phase_d        = PH_IDLE;
							sub_d          = 2'd0;
							res_d.done_res = 1'b1;
							res_d.status   = ST_START_FAIL;
						end else begin
							sda_d = 1'b0;
							sub_d = 2'd2;
						end
					end else begin
						if (sda) begin
							scl_d          = 1'b1;
							sda_d          = 1'b1;
							phase_d        = PH_IDLE;
							sub_d          = 2'd0;
							res_d.done_res = 1'b1;
							res_d.status   = ST_START_FAIL;
						end else begin
							scl_d   = 1'b0;
							sub_d   = 2'd0;
							bits_d  = 4'd0;
							if (phase_q == PH_START1) begin
								phase_d = PH_DEVW;
								shift_d = dev_addr;
							end else begin
								phase_d = PH_DEVR;
								shift_d = dev_addr + 8'd1;
							end
						end
					end
				end
				// send a byte, then clock the device ack
				PH_DEVW, PH_REG, PH_WDATA, PH_DEVR: begin
					if (bits_q < 4'd8) begin
						if (sub_q == 2'd0) begin
							scl_d = 1'b0;
							sub_d = 2'd1;
						end else if (sub_q == 2'd1) begin
							sda_d = shift_q[7];
							sub_d = 2'd2;
						end else begin
							scl_d   = 1'b1;
							shift_d = {shift_q[6:0], 1'b0};
							bits_d  = bits_q + 4'd1;
							sub_d   = 2'd0;
						end
					end else if (sub_q == 2'd0) begin
						scl_d = 1'b0;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						sda_d = 1'b1;
						sub_d = 2'd2;
					end else if (sub_q == 2'd2) begin
						scl_d = 1'b1;
						sub_d = 2'd3;
					end else begin
						scl_d  = 1'b0;
						sub_d  = 2'd0;
						bits_d = 4'd0;
						unique case (phase_q)
							PH_DEVW: begin
								if (!sda) begin
									phase_d = PH_REG;
									shift_d = reg_addr_q;
								end else begin
									phase_d = PH_STOP_ABORT;
								end
							end
							PH_REG: begin
								if (rd_mode_q) begin
									phase_d = PH_STOP_MID;
								end else begin
									phase_d = PH_WDATA;
									shift_d = wdata_q;
								end
							end
							PH_WDATA: begin
								phase_d = PH_STOP_END;
							end
							default: begin
								if (sda) begin
									phase_d = PH_STOP_ABORT;
								end else if (left_q == 5'd0) begin
									phase_d = PH_STOP_END;
								end else begin
									phase_d = PH_RBYTE;
									shift_d = 8'h00;
								end
							end
						endcase
					end
				end
				// receive a byte, then master ack or nack
				PH_RBYTE: begin
					if (bits_q < 4'd8) begin
						if (sub_q == 2'd0) begin
							scl_d = 1'b0;
							sda_d = 1'b1;
							sub_d = 2'd1;
						end else if (sub_q == 2'd1) begin
							scl_d = 1'b1;
							sub_d = 2'd2;
						end else begin
							shift_d = shift_in;
							scl_d   = 1'b0;
							bits_d  = bits_q + 4'd1;
							sub_d   = 2'd0;
							if (bits_q == 4'd7) begin
								res_d.data_valid = 1'b1;
								res_d.read_data  = shift_in;
								res_d.data_last  = (left_q == 5'd1);
							end
						end
					end else if (sub_q == 2'd0) begin
						scl_d = 1'b0;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						sda_d = (left_q <= 5'd1);
						sub_d = 2'd2;
					end else if (sub_q == 2'd2) begin
						scl_d = 1'b1;
						sub_d = 2'd3;
					end else begin
						scl_d  = 1'b0;
						left_d = left_dec;
						sub_d  = 2'd0;
						bits_d = 4'd0;
						if (left_dec == 5'd0) begin
							phase_d = PH_STOP_END;
						end else begin
							phase_d = PH_RBYTE;
							shift_d = 8'h00;
						end
					end
				end
				// stop condition, then restart or finish
				PH_STOP_MID, PH_STOP_END, PH_STOP_ABORT: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b0;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						sda_d = 1'b0;
						sub_d = 2'd2;
					end else if (sub_q == 2'd2) begin
						scl_d = 1'b1;
						sub_d = 2'd3;
					end else begin
						sda_d = 1'b1;
						sub_d = 2'd0;
						if (phase_q == PH_STOP_MID) begin
							phase_d = PH_START2;
						end else begin
							res_d.done_res = 1'b1;
							res_d.status   = (phase_q == PH_STOP_ABORT) ? ST_NO_ACK : ST_OK;
							phase_d        = PH_IDLE;
						end
					end
				end
				// unused phase codes fall back to idle
				default: begin
					phase_d = PH_IDLE;
					sub_d   = 2'd0;
					scl_d   = 1'b1;
					sda_d   = 1'b1;
				end
			endcase
		end

		res_d.scl_level = scl_d;
		res_d.sda_level = sda_d;
		res_d.busy_res  = (phase_d != PH_IDLE);
	end

	// protocol state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			sub_q      <= 2'd0;
			bits_q     <= 4'd0;
			shift_q    <= 8'h00;
			left_q     <= 5'd0;
			reg_addr_q <= 8'h00;
			wdata_q    <= 8'h00;
			rd_mode_q  <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			res_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			sub_q      <= sub_d;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			left_q     <= left_d;
			reg_addr_q <= reg_addr_d;
			wdata_q    <= wdata_d;
			rd_mode_q  <= rd_mode_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			res_q      <= res_d;
		end
	end

	assign res = res_q;

endmodule

[rtl/core/sccb_bus_master.sv]
// sccb_bus_master: bit-level sccb master, one bus half-period per tick request
// path: a tick is held in the input register, then its result in the result register; it waits while the result is held
// throughput: one tick per cycle while results are taken, the sequencer advances one half-period per tick
// reset: idle with both lines released, device write address 0x42, no result pending
// depends on sccb_pkg, sccb_ifs and sccb_engine
module sccb_bus_master import sccb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	sccb_cmd_if.sink   cmd,
	sccb_res_if.source res,
	sccb_cfg_if.sink   cfg
);

	logic       valid_s1;
	cmd_t       item_s1;
	logic       valid_s2;
	logic       out_free;
	logic       step;
	logic [7:0] dev_addr_q;
	res_t       res_s2;

	assign out_free  = !valid_s2 || res.ready;
	assign step      = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || step;
	assign cfg.ready = 1'b1;

	// device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg.valid) begin
			dev_addr_q <= cfg.data;
		end
	end

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.payload;
		end
	end

	// result valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	sccb_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.dev_addr (dev_addr_q),
		.res      (res_s2)
	);

	assign res.valid   = valid_s2;
	assign res.payload = res_s2;

`ifndef SYNTHESIS
	// a finished transaction never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while busy");

	// status only accompanies done
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status != ST_OK) |-> res_s2.done_res)
		else $error("status without done");

	// last-byte flag only with a received byte
	a_last_with_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.data_last |-> res_s2.data_valid)
		else $error("data_last without data_valid");

	// a held tick blocks new requests until the result slot frees
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |-> !cmd.ready)
		else $error("input accepted while stage one stalled");
`endif

endmodule

[sim/sccb_bus_master_tb.sv]
// sccb_bus_master_tb: self-checking bench for the bit-level sccb bus master
// a scripted set of transfers, then random transfers against an emulated bus device
// depends on sccb_pkg, sccb_ifs and sccb_bus_master
`timescale 1ns / 1ps

module sccb_bus_master_tb;
	import sccb_pkg::*;

	// kind code the block treats as a plain tick
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// bus sequencer phases of the prediction
	typedef enum logic [3:0] {
		BUS_IDLE, BUS_START, BUS_DEV_WR, BUS_REG, BUS_DATA, BUS_STOP_MID,
		BUS_RESTART, BUS_DEV_RD, BUS_RECV, BUS_STOP, BUS_ABORT
	} bus_phase_e;

	// how the emulated device answers on sda
	typedef enum logic [2:0] {
		DEV_ACKS, DEV_NO_WR_ACK, DEV_NO_RD_ACK, DEV_HOLDS_LOW, DEV_STUCK_HIGH
	} dev_mode_e;

	// one scripted transfer: command, device address, device behavior, final status
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [4:0] length;
		logic [7:0] dev;
		dev_mode_e  mode;
		logic       poke;
		logic [1:0] want;
	} xfer_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sccb_cmd_if cmd_ch ();
	sccb_res_if res_ch ();
	sccb_cfg_if cfg_ch ();

	sccb_bus_master DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// predicted bus master state
	bus_phase_e bus_ph;
	logic [1:0] half;
	logic [3:0] bit_no;
	logic [7:0] shifter;
	logic [4:0] bytes_due;
	logic [7:0] cmd_reg;
	logic [7:0] cmd_data;
	logic       reading;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] dev_addr;

	res_t levels_due [$];
	int   mismatches = 0;
	int   items_sent = 0;
	bit   quiet = 1'b0;
	bit   stall_request = 1'b0;
	int   stall_left = 0;

	xfer_row_t script [0:15] = '{
		'{KIND_TICK,  8'h00, 8'h00, 5'd0,  8'h42, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_WRITE, 8'h00, 8'h00, 5'd0,  8'h42, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_WRITE, 8'hff, 8'hff, 5'd31, 8'h42, DEV_ACKS,       1'b1, ST_OK},
		'{KIND_WRITE, 8'h5a, 8'ha5, 5'd0,  8'h42, DEV_HOLDS_LOW,  1'b0, ST_START_FAIL},
		'{KIND_WRITE, 8'h11, 8'h22, 5'd0,  8'h42, DEV_STUCK_HIGH, 1'b0, ST_START_FAIL},
		'{KIND_WRITE, 8'h33, 8'h44, 5'd0,  8'h42, DEV_NO_WR_ACK,  1'b0, ST_NO_ACK},
		'{KIND_READ,  8'h80, 8'h00, 5'd0,  8'h42, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_READ,  8'h01, 8'hff, 5'd1,  8'h42, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_READ,  8'h7f, 8'h00, 5'd3,  8'h42, DEV_NO_RD_ACK,  1'b0, ST_NO_ACK},
		'{KIND_READ,  8'hc3, 8'h00, 5'd3,  8'h42, DEV_NO_WR_ACK,  1'b0, ST_NO_ACK},
		'{KIND_READ,  8'h3c, 8'h00, 5'd3,  8'h42, DEV_HOLDS_LOW,  1'b0, ST_START_FAIL},
		'{KIND_SPARE, 8'hff, 8'hff, 5'd31, 8'h42, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_READ,  8'h00, 8'h00, 5'd31, 8'h00, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_READ,  8'hff, 8'h00, 5'd16, 8'hff, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_WRITE, 8'haa, 8'h55, 5'd0,  8'hff, DEV_ACKS,       1'b0, ST_OK},
		'{KIND_READ,  8'h96, 8'h69, 5'd2,  8'ha5, DEV_ACKS,       1'b1, ST_OK}
	};

	// clock
	always #1 clk = ~clk;

	// load a byte for shifting and enter its phase
	function automatic void open_byte(bus_phase_e p, logic [7:0] b);
		bus_ph = p;
		half = 2'd0;
		bit_no = 4'd0;
		shifter = b;
	endfunction

	// advance the predicted bus by one half-period tick, return the bus levels
	function automatic res_t advance_bus(cmd_t c);
		res_t r;
		logic is_cmd;
		logic fail;
		r = '0;
		is_cmd = (c.kind == KIND_WRITE) || (c.kind == KIND_READ);
		if (bus_ph == BUS_IDLE) begin
			if (is_cmd) begin
				cmd_reg = c.reg_addr;
				cmd_data = c.write_data;
				reading = (c.kind == KIND_READ);
				bytes_due = (c.read_length > MAX_READ_LEN) ? MAX_READ_LEN : c.read_length;
				scl_q = 1'b1;
				sda_q = 1'b1;
				bus_ph = BUS_START;
				half = 2'd1;
			end
		end else begin
			r.rejected = is_cmd;
			case (bus_ph)
				// start: sda must read high before the fall, low after it
				BUS_START, BUS_RESTART: begin
					fail = (half == 2'd1) ? !c.sda_in : c.sda_in;
					if (half == 2'd0) begin
						scl_q = 1'b1;
						sda_q = 1'b1;
						half = 2'd1;
					end else if (fail) begin
						scl_q = 1'b1;
						sda_q = 1'b1;
						bus_ph = BUS_IDLE;
						half = 2'd0;
						r.done_res = 1'b1;
						r.status = ST_START_FAIL;
					end else if (half == 2'd1) begin
						sda_q = 1'b0;
						half = 2'd2;
					end else begin
						scl_q = 1'b0;
						if (bus_ph == BUS_START)
							open_byte(BUS_DEV_WR, dev_addr);
						else
							open_byte(BUS_DEV_RD, dev_addr + 8'd1);
					end
				end
				// byte out, msb first, then the device ack slot
				BUS_DEV_WR, BUS_REG, BUS_DATA, BUS_DEV_RD: begin
					if (bit_no < 4'd8) begin
						case (half)
							2'd0: begin
								scl_q = 1'b0;
								half = 2'd1;
							end
							2'd1: begin
								sda_q = shifter[7];
								half = 2'd2;
							end
							default: begin
								scl_q = 1'b1;
								shifter = shifter << 1;
								bit_no = bit_no + 4'd1;
								half = 2'd0;
							end
						endcase
					end else begin
						case (half)
							2'd0: begin
								scl_q = 1'b0;
								half = 2'd1;
							end
							2'd1: begin
								sda_q = 1'b1;
								half = 2'd2;
							end
							2'd2: begin
								scl_q = 1'b1;
								half = 2'd3;
							end
							default: begin
								scl_q = 1'b0;
								half = 2'd0;
								bit_no = 4'd0;
								// acks on the register and data bytes are not checked
								case (bus_ph)
									BUS_DEV_WR: begin
										if (!c.sda_in)
											open_byte(BUS_REG, cmd_reg);
										else
											bus_ph = BUS_ABORT;
									end
									BUS_REG: begin
										if (reading)
											bus_ph = BUS_STOP_MID;
										else
											open_byte(BUS_DATA, cmd_data);
									end
									BUS_DATA: bus_ph = BUS_STOP;
									default: begin
										if (c.sda_in)
											bus_ph = BUS_ABORT;
										else if (bytes_due == 5'd0)
											bus_ph = BUS_STOP;
										else
											open_byte(BUS_RECV, 8'h00);
									end
								endcase
							end
						endcase
					end
				end
				// byte in, then master ack, nack on the last byte
				BUS_RECV: begin
					if (bit_no < 4'd8) begin
						case (half)
							2'd0: begin
								scl_q = 1'b0;
								sda_q = 1'b1;
								half = 2'd1;
							end
							2'd1: begin
								scl_q = 1'b1;
								half = 2'd2;
							end
							default: begin
								shifter = {shifter[6:0], c.sda_in};
								scl_q = 1'b0;
								bit_no = bit_no + 4'd1;
								half = 2'd0;
								if (bit_no == 4'd8) begin
									r.data_valid = 1'b1;
									r.read_data = shifter;
									r.data_last = (bytes_due == 5'd1);
								end
							end
						endcase
					end else begin
						case (half)
							2'd0: begin
								scl_q = 1'b0;
								half = 2'd1;
							end
							2'd1: begin
								sda_q = (bytes_due <= 5'd1);
								half = 2'd2;
							end
							2'd2: begin
								scl_q = 1'b1;
								half = 2'd3;
							end
							default: begin
								scl_q = 1'b0;
								if (bytes_due > 5'd0)
									bytes_due = bytes_due - 5'd1;
								if (bytes_due == 5'd0) begin
									bus_ph = BUS_STOP;
									half = 2'd0;
									bit_no = 4'd0;
								end else begin
									open_byte(BUS_RECV, 8'h00);
								end
							end
						endcase
					end
				end
				// stop, the mid-read one leads into the restart
				BUS_STOP_MID, BUS_STOP, BUS_ABORT: begin
					case (half)
						2'd0: begin
							scl_q = 1'b0;
							half = 2'd1;
						end
						2'd1: begin
							sda_q = 1'b0;
							half = 2'd2;
						end
						2'd2: begin
							scl_q = 1'b1;
							half = 2'd3;
						end
						default: begin
							sda_q = 1'b1;
							half = 2'd0;
							if (bus_ph == BUS_STOP_MID) begin
								bus_ph = BUS_RESTART;
							end else begin
								r.done_res = 1'b1;
								r.status = (bus_ph == BUS_ABORT) ? ST_NO_ACK : ST_OK;
								bus_ph = BUS_IDLE;
							end
						end
					endcase
				end
				default: begin
					bus_ph = BUS_IDLE;
					half = 2'd0;
					scl_q = 1'b1;
					sda_q = 1'b1;
				end
			endcase
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res = (bus_ph != BUS_IDLE);
		return r;
	endfunction

	// sda level the emulated device presents on the coming tick
	function automatic logic device_sda(dev_mode_e m, bit noisy);
		logic v;
		v = 1'($urandom_range(1));
		if (bus_ph == BUS_START || bus_ph == BUS_RESTART) begin
			if (half == 2'd1)
				v = (m != DEV_HOLDS_LOW);
			else if (half == 2'd2)
				v = (m == DEV_STUCK_HIGH);
		end else if (bit_no == 4'd8 && half == 2'd3) begin
			if (bus_ph == BUS_DEV_WR)
				v = (m == DEV_NO_WR_ACK);
			else if (bus_ph == BUS_DEV_RD)
				v = (m == DEV_NO_RD_ACK);
		end
		if (noisy && $urandom_range(99) < 8)
			v = ~v;
		return v;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// offer one tick request, predict it once accepted, then maybe idle
	task automatic push_tick(cmd_t c, bit typed, logic [1:0] want);
		res_t r;
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		r = advance_bus(c);
		if (typed && r.done_res)
			r.status = want;
		levels_due.push_back(r);
		items_sent++;
		if (!quiet) begin
			while ($urandom_range(99) < 38) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// run one command until the predicted bus is idle again
	task automatic run_transfer(logic [1:0] k, logic [7:0] ra, logic [7:0] wd,
			logic [4:0] len, dev_mode_e m, bit noisy, bit poke, bit typed,
			logic [1:0] want);
		cmd_t c;
		int n;
		n = 0;
		do begin
			c.kind = (n == 0) ? k : KIND_TICK;
			// commands mid-transfer must be turned away
			if (poke && n == 5)
				c.kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
			if (poke && n == 9)
				c.kind = KIND_SPARE;
			c.reg_addr = (n == 0) ? ra : 8'($urandom);
			c.write_data = (n == 0) ? wd : 8'($urandom);
			c.read_length = (n == 0) ? len : 5'($urandom);
			c.sda_in = device_sda(m, noisy);
			push_tick(c, typed, want);
			n++;
		end while (bus_ph != BUS_IDLE);
	endtask

	// stop offering and wait for every pending result
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		wait (levels_due.size() == 0);
	endtask

	task automatic write_dev_addr(logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		dev_addr = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random back-pressure with one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_left = 150;
				stall_request = 1'b0;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				res_ch.ready <= quiet || ($urandom_range(99) >= 38);
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (levels_due.size() == 0) begin
				flag_mismatch("result with nothing pending");
			end else begin
				want = levels_due.pop_front();
				check_field("scl_level", res_ch.payload.scl_level, want.scl_level);
				check_field("sda_level", res_ch.payload.sda_level, want.sda_level);
				check_field("busy_res", res_ch.payload.busy_res, want.busy_res);
				check_field("done_res", res_ch.payload.done_res, want.done_res);
				check_field("status", res_ch.payload.status, want.status);
				check_field("data_valid", res_ch.payload.data_valid, want.data_valid);
				check_field("read_data", res_ch.payload.read_data, want.read_data);
				check_field("data_last", res_ch.payload.data_last, want.data_last);
				check_field("rejected", res_ch.payload.rejected, want.rejected);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int phase_end;
		int pick;
		logic [1:0] k;
		logic [4:0] len;
		dev_mode_e m;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 8'h00;
		bus_ph = BUS_IDLE;
		half = 2'd0;
		bit_no = 4'd0;
		shifter = 8'h00;
		bytes_due = 5'd0;
		cmd_reg = 8'h00;
		cmd_data = 8'h00;
		reading = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		dev_addr = DEV_ADDR_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted transfers, final status typed in per row
		foreach (script[i]) begin
			if (script[i].dev != dev_addr) begin
				drain();
				write_dev_addr(script[i].dev);
			end
			run_transfer(script[i].kind, script[i].reg_addr, script[i].write_data,
				script[i].length, script[i].mode, 1'b0, script[i].poke, 1'b1,
				script[i].want);
		end

		// random transfers in four address settings
		for (int p = 0; p < 4; p++) begin
			drain();
			write_dev_addr((p == 0) ? 8'd254 : 8'($urandom));
			quiet = (p == 1);
			if (p == 2)
				stall_request = 1'b1;
			phase_end = items_sent + 313;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				k = (pick < 50) ? KIND_WRITE : (pick < 94) ? KIND_READ :
					(pick < 97) ? KIND_TICK : KIND_SPARE;
				pick = $urandom_range(99);
				len = (pick < 80) ? 5'($urandom_range(2)) :
					(pick < 95) ? 5'($urandom_range(16, 3)) : 5'($urandom_range(31, 17));
				pick = $urandom_range(99);
				m = (pick < 76) ? DEV_ACKS : (pick < 82) ? DEV_NO_WR_ACK :
					(pick < 88) ? DEV_NO_RD_ACK : (pick < 94) ? DEV_HOLDS_LOW :
					DEV_STUCK_HIGH;
				run_transfer(k, 8'($urandom), 8'($urandom), len, m,
					$urandom_range(99) < 15, $urandom_range(99) < 20, 1'b0, ST_OK);
			end
		end
		quiet = 1'b0;

		// let the pipeline empty, then report
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("sccb_bus_master_tb: done, clean");
		else
			$display("sccb_bus_master_tb: done, errors");
		$finish;
	end

	// run limit, many times the slowest expected run
	initial begin
		#400000;
		$display("sccb_bus_master_tb: done, errors");
		$finish;
	end

endmodule
